>>> design/sem_pkg.sv
// Shared constants and types for the Sobel edge strength block.
// No dependencies; imported by sem_cell, the top unit and bench.
package sem_pkg;

	// parameter defaults
	localparam int MAX_COLUMNS_DEF  = 1024;
	localparam int CHANNEL_BITS_DEF = 8;

	// configuration port
	localparam int CFG_WIDTH     = 11;
	localparam int CFG_IDX_WIDTH = 1;

	typedef enum logic [CFG_IDX_WIDTH-1:0] {
		CFG_IMAGE_COLUMNS = 1'b0,
		CFG_IMAGE_ROWS    = 1'b1
	} cfg_idx_t;

	localparam logic [CFG_WIDTH-1:0] COLS_RESET = 11'd1024;
	localparam logic [CFG_WIDTH-1:0] ROWS_RESET = 11'd1024;

	// frame geometry limits
	localparam int MIN_DIM  = 3;
	localparam int MAX_ROWS = 1024;

	// width of the reported row and column positions
	localparam int POS_WIDTH = 10;

	// control handed to every window column cell
	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctl_t;

endpackage

>>> design/sem_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the line stores.
module sem_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port, holds while not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> design/sem_cell.sv
// One column of the 3x3 window: three gray values that move one place to the
// left on every shift, plus the column terms of both Sobel sums. Uses sem_pkg.
module sem_cell #(
	parameter int CHANNEL_BITS = sem_pkg::CHANNEL_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  sem_pkg::cell_ctl_t      ctl,
	input  logic [CHANNEL_BITS-1:0] top_in,
	input  logic [CHANNEL_BITS-1:0] mid_in,
	input  logic [CHANNEL_BITS-1:0] bot_in,
	output logic [CHANNEL_BITS-1:0] top_out,
	output logic [CHANNEL_BITS-1:0] mid_out,
	output logic [CHANNEL_BITS-1:0] bot_out,
	output logic signed [CHANNEL_BITS:0] col_diff,
	output logic [CHANNEL_BITS+1:0] col_sum
);
	import sem_pkg::*;

	localparam int SW = CHANNEL_BITS + 2;

	logic [CHANNEL_BITS-1:0] top_q, mid_q, bot_q;

	// column registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= '0;
			mid_q <= '0;
			bot_q <= '0;
		end else if (ctl.clear) begin
			top_q <= '0;
			mid_q <= '0;
			bot_q <= '0;
		end else if (ctl.shift) begin
			top_q <= top_in;
			mid_q <= mid_in;
			bot_q <= bot_in;
		end
	end

	assign top_out = top_q;
	assign mid_out = mid_q;
	assign bot_out = bot_q;

	// bottom minus top feeds gx, top + 2*mid + bottom feeds gy
	assign col_diff = $signed({1'b0, bot_q}) - $signed({1'b0, top_q});
	assign col_sum  = SW'(top_q) + SW'({mid_q, 1'b0}) + SW'(bot_q);

endmodule

>>> design/sobel_edge_max_abs_unit.sv
// Sobel edge strength unit: RGB pixels in raster order, one pixel per clock
// unless results back up. Each pixel becomes gray (r+g+b)/3; two line-store
// RAMs and a row of three window column cells form the 3x3 neighborhood,
// and every interior pixel yields max(|gx|,|gy|) with its row and column,
// tlast on the frame's final result. Sustained rate is one pixel per cycle
// while the output accepts; a result passes the RAM read, window shift,
// Sobel sums and the output register after the pixel that completes its
// window (the one below and right of the centre) is transferred. Border
// pixels give no result. Any configuration write restarts the frame at row
// 0, column 0. Depends on sem_pkg, sem_ram and sem_cell.
module sobel_edge_max_abs_unit #(
	parameter int MAX_COLUMNS  = sem_pkg::MAX_COLUMNS_DEF,
	parameter int CHANNEL_BITS = sem_pkg::CHANNEL_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration writes
	input  logic                                 cfg_wr_en,
	input  logic [sem_pkg::CFG_IDX_WIDTH-1:0]    cfg_index,
	input  logic [sem_pkg::CFG_WIDTH-1:0]        cfg_data,
	// pixel input
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// red_in, green_in, blue_in
	input  logic [((3*CHANNEL_BITS+7)/8)*8-1:0]  s_axis_tdata,
	// result output
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// edge_strength, centre_row, centre_column
	output logic [((CHANNEL_BITS+2+2*sem_pkg::POS_WIDTH+7)/8)*8-1:0] m_axis_tdata,
	// frame_last
	output logic                                 m_axis_tlast
);
	import sem_pkg::*;

	localparam int CB     = CHANNEL_BITS;
	localparam int COL_W  = $clog2(MAX_COLUMNS);
	localparam int CMP_W  = (COL_W + 1 > CFG_WIDTH) ? COL_W + 1 : CFG_WIDTH;
	localparam int ROW_W  = POS_WIDTH;
	localparam int SUM_W  = CB + 2;
	localparam int SHIFT  = SUM_W + 1;
	localparam logic [SHIFT-1:0] RECIP = SHIFT'((2**SHIFT + 2) / 3);
	localparam int PROD_W = SUM_W + SHIFT;
	localparam int GX_W   = CB + 3;
	localparam int ABS_W  = CB + 2;
	localparam int OUT_W  = ((ABS_W + 2*POS_WIDTH + 7) / 8) * 8;

	// ---------------- configuration and position counters ----------------
	logic [CFG_WIDTH-1:0] cols_q, rows_q;
	logic [COL_W-1:0]     col_q;
	logic [ROW_W-1:0]     row_q;
	logic [CMP_W-1:0]     cols_w, eff_cols;
	logic [CFG_WIDTH-1:0] eff_rows;
	logic                 col_last, row_last;
	logic                 in_xfer;

	assign cols_w   = CMP_W'(cols_q);
	assign eff_cols = (cols_w < CMP_W'(MIN_DIM)) ? CMP_W'(MIN_DIM) :
	                  (cols_w > CMP_W'(MAX_COLUMNS)) ? CMP_W'(MAX_COLUMNS) : cols_w;
	assign eff_rows = (rows_q < CFG_WIDTH'(MIN_DIM)) ? CFG_WIDTH'(MIN_DIM) :
	                  (rows_q > CFG_WIDTH'(MAX_ROWS)) ? CFG_WIDTH'(MAX_ROWS) : rows_q;
	assign col_last = (CMP_W'(col_q) + CMP_W'(1)) >= eff_cols;
	assign row_last = (CFG_WIDTH'(row_q) + CFG_WIDTH'(1)) >= eff_rows;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= COLS_RESET;
			rows_q <= ROWS_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_IMAGE_COLUMNS: cols_q <= cfg_data;
				CFG_IMAGE_ROWS:    rows_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// raster position of the next pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_wr_en) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_xfer) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= row_last ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// ---------------- handshake chain ----------------
	logic valid_s1, valid_s2, valid_s3, out_valid_q;
	logic ready_s2, ready_s3, ready_o;
	logic adv_s1, adv_s2, adv_s3;

	assign ready_o       = !out_valid_q || m_axis_tready;
	assign ready_s3      = !valid_s3 || ready_o;
	assign ready_s2      = !valid_s2 || ready_s3;
	assign s_axis_tready = !valid_s1 || ready_s2;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign adv_s1        = valid_s1 && ready_s2;
	assign adv_s2        = valid_s2 && ready_s3;
	assign adv_s3        = valid_s3 && ready_o;

	// ---------------- stage 1: channel sum, line store read ----------------
	logic [CB-1:0]        red_in, green_in, blue_in;
	logic [SUM_W-1:0]     sum_s1;
	logic [COL_W-1:0]     col_s1;
	logic                 produce_s1, last_s1;
	logic [POS_WIDTH-1:0] crow_s1, ccol_s1;
	logic [COL_W-1:0]     col_m1;
	logic [CMP_W-1:0]     col_m1_w;

	assign red_in   = s_axis_tdata[0 +: CB];
	assign green_in = s_axis_tdata[CB +: CB];
	assign blue_in  = s_axis_tdata[2*CB +: CB];
	assign col_m1   = col_q - COL_W'(1);
	assign col_m1_w = CMP_W'(col_m1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			sum_s1     <= SUM_W'(red_in) + SUM_W'(green_in) + SUM_W'(blue_in);
			col_s1     <= col_q;
			produce_s1 <= (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2));
			last_s1    <= row_last && col_last;
			crow_s1    <= row_q - ROW_W'(1);
			ccol_s1    <= col_m1_w[POS_WIDTH-1:0];
		end
	end

	// line stores: upper holds two rows back, middle one row back
	logic [CB-1:0]     upper_rd, middle_rd, gray;
	logic [PROD_W-1:0] gray_prod;

	// divide by three as multiply by reciprocal
	assign gray_prod = PROD_W'(sum_s1) * PROD_W'(RECIP);
	assign gray      = gray_prod[SHIFT +: CB];

	sem_ram #(.WIDTH(CB), .DEPTH(MAX_COLUMNS)) u_upper_ram (
		.clk     (clk),
		.wr_en   (adv_s1),
		.wr_addr (col_s1),
		.wr_data (middle_rd),
		.rd_en   (in_xfer),
		.rd_addr (col_q),
		.rd_data (upper_rd)
	);

	sem_ram #(.WIDTH(CB), .DEPTH(MAX_COLUMNS)) u_middle_ram (
		.clk     (clk),
		.wr_en   (adv_s1),
		.wr_addr (col_s1),
		.wr_data (gray),
		.rd_en   (in_xfer),
		.rd_addr (col_q),
		.rd_data (middle_rd)
	);

	// ---------------- stage 2: window column cells ----------------
	cell_ctl_t            cell_ctl;
	logic [CB-1:0]        top_w [3];
	logic [CB-1:0]        mid_w [3];
	logic [CB-1:0]        bot_w [3];
	logic signed [CB:0]   diff_w [3];
	logic [CB+1:0]        csum_w [3];
	logic                 last_s2;
	logic [POS_WIDTH-1:0] crow_s2, ccol_s2;

	assign cell_ctl.shift = adv_s1;
	assign cell_ctl.clear = cfg_wr_en;

	for (genvar j = 0; j < 3; j++) begin : g_cell
		logic [CB-1:0] top_src, mid_src, bot_src;
		if (j == 2) begin : g_newest
			assign top_src = upper_rd;
			assign mid_src = middle_rd;
			assign bot_src = gray;
		end else begin : g_chain
			assign top_src = top_w[j+1];
			assign mid_src = mid_w[j+1];
			assign bot_src = bot_w[j+1];
		end
		sem_cell #(.CHANNEL_BITS(CB)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (cell_ctl),
			.top_in   (top_src),
			.mid_in   (mid_src),
			.bot_in   (bot_src),
			.top_out  (top_w[j]),
			.mid_out  (mid_w[j]),
			.bot_out  (bot_w[j]),
			.col_diff (diff_w[j]),
			.col_sum  (csum_w[j])
		);
	end

	// only interior pixels continue past the window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= produce_s1;
		end else if (adv_s2) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			last_s2 <= last_s1;
			crow_s2 <= crow_s1;
			ccol_s2 <= ccol_s1;
		end
	end

	// ---------------- stage 3: Sobel sums ----------------
	logic signed [GX_W-1:0] gx, gy, gx_s3, gy_s3;
	logic                   last_s3;
	logic [POS_WIDTH-1:0]   crow_s3, ccol_s3;

	assign gx = GX_W'(diff_w[0]) + (GX_W'(diff_w[1]) <<< 1) + GX_W'(diff_w[2]);
	assign gy = $signed({1'b0, csum_w[2]}) - $signed({1'b0, csum_w[0]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv_s2) begin
			valid_s3 <= 1'b1;
		end else if (adv_s3) begin
			valid_s3 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			gx_s3   <= gx;
			gy_s3   <= gy;
			last_s3 <= last_s2;
			crow_s3 <= crow_s2;
			ccol_s3 <= ccol_s2;
		end
	end

	// ---------------- output register: max of magnitudes ----------------
	logic signed [GX_W-1:0] gx_neg, gy_neg;
	logic [ABS_W-1:0]       ax, ay;
	logic [ABS_W-1:0]       edge_q;
	logic [POS_WIDTH-1:0]   crow_q, ccol_q;
	logic                   last_q;

	assign gx_neg = -gx_s3;
	assign gy_neg = -gy_s3;
	assign ax     = gx_s3[GX_W-1] ? gx_neg[ABS_W-1:0] : gx_s3[ABS_W-1:0];
	assign ay     = gy_s3[GX_W-1] ? gy_neg[ABS_W-1:0] : gy_s3[ABS_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s3) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			edge_q <= (ax > ay) ? ax : ay;
			crow_q <= crow_s3;
			ccol_q <= ccol_s3;
			last_q <= last_s3;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_W'({ccol_q, crow_q, edge_q});
	assign m_axis_tlast  = last_q;

endmodule

>>> test/sobel_edge_max_abs_unit_test.sv
// Self-checking testbench for sobel_edge_max_abs_unit: RGB pixel stream in,
// edge strength results out, checked against an in-bench predictor.
// Depends on sem_pkg and the sobel_edge_max_abs_unit RTL only.
`timescale 1ns / 100ps

module sobel_edge_max_abs_unit_test;
	import sem_pkg::*;

	localparam int CHANNEL_BITS   = CHANNEL_BITS_DEF;
	localparam int MAX_COLUMNS    = MAX_COLUMNS_DEF;
	localparam int IN_WIDTH       = ((3*CHANNEL_BITS+7)/8)*8;
	localparam int OUT_WIDTH      = ((CHANNEL_BITS+2+2*POS_WIDTH+7)/8)*8;
	// drain margin once every expected result has arrived
	localparam int SETTLE_CYCLES  = 12;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_PIXELS  = 1300;

	typedef struct packed {
		logic [CHANNEL_BITS-1:0] blue;
		logic [CHANNEL_BITS-1:0] green;
		logic [CHANNEL_BITS-1:0] red;
	} pixel_t;

	typedef struct packed {
		logic [POS_WIDTH-1:0] strength;
		logic [POS_WIDTH-1:0] row;
		logic [POS_WIDTH-1:0] col;
		logic                 frame_end;
	} edge_result_t;

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_wr_en;
	logic [CFG_IDX_WIDTH-1:0] cfg_index;
	logic [CFG_WIDTH-1:0]     cfg_data;
	logic                     s_axis_tvalid;
	logic                     s_axis_tready;
	// red_in, green_in, blue_in
	logic [IN_WIDTH-1:0]      s_axis_tdata;
	logic                     m_axis_tvalid;
	logic                     m_axis_tready;
	// edge_strength, centre_row, centre_column, zero fill
	logic [OUT_WIDTH-1:0]     m_axis_tdata;
	logic                     m_axis_tlast;

	sobel_edge_max_abs_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	// predictor state: registers, line stores, window, raster position
	logic [CFG_WIDTH-1:0] cols_reg;
	logic [CFG_WIDTH-1:0] rows_reg;
	int                   upper_line[MAX_COLUMNS];
	int                   middle_line[MAX_COLUMNS];
	int                   win[3][3];
	int                   row_pos;
	int                   col_pos;

	edge_result_t expected_edges[$];
	int           pixels_sent;
	int           edges_checked;
	int           reg_writes;
	int           mismatches;
	int           send_idle_pct;
	int           stall_pct;
	bit           hold_active;
	event         hold_start;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int clamp_dim(logic [CFG_WIDTH-1:0] v, int hi);
		if (v < MIN_DIM)
			return MIN_DIM;
		if (v > hi)
			return hi;
		return int'(v);
	endfunction

	// any register write starts a new frame
	function automatic void restart_frame();
		row_pos = 0;
		col_pos = 0;
		for (int k = 0; k < 3; k++) begin
			for (int j = 0; j < 3; j++)
				win[k][j] = 0;
		end
	endfunction

	// advance the window by one pixel and queue the edge result it completes
	function automatic void predict_edge(pixel_t px);
		int cols;
		int rows;
		int gray;
		int gx;
		int gy;
		int ax;
		int ay;
		edge_result_t res;
		cols = clamp_dim(cols_reg, MAX_COLUMNS);
		rows = clamp_dim(rows_reg, MAX_ROWS);
		gray = (int'(px.red) + int'(px.green) + int'(px.blue)) / 3;
		for (int k = 0; k < 3; k++) begin
			win[k][0] = win[k][1];
			win[k][1] = win[k][2];
		end
		win[0][2] = upper_line[col_pos];
		win[1][2] = middle_line[col_pos];
		win[2][2] = gray;
		upper_line[col_pos] = middle_line[col_pos];
		middle_line[col_pos] = gray;
		if (row_pos >= 2 && col_pos >= 2) begin
			gx = -win[0][0] - 2*win[0][1] - win[0][2] + win[2][0] + 2*win[2][1] + win[2][2];
			gy = -win[0][0] + win[0][2] - 2*win[1][0] + 2*win[1][2] - win[2][0] + win[2][2];
			ax = (gx < 0) ? -gx : gx;
			ay = (gy < 0) ? -gy : gy;
			res.strength = POS_WIDTH'((ax > ay) ? ax : ay);
			res.row = POS_WIDTH'(row_pos - 1);
			res.col = POS_WIDTH'(col_pos - 1);
			res.frame_end = (row_pos + 1 >= rows) && (col_pos + 1 >= cols);
			expected_edges.push_back(res);
		end
		if (col_pos + 1 >= cols) begin
			col_pos = 0;
			row_pos = (row_pos + 1 >= rows) ? 0 : row_pos + 1;
		end else begin
			col_pos = col_pos + 1;
		end
	endfunction

	task automatic report_mismatch(string msg);
		mismatches++;
		$display("[%0t] MISMATCH: %s", $time, msg);
	endtask

	// result checker
	initial begin
		edge_result_t want;
		logic [POS_WIDTH-1:0] got_strength;
		logic [POS_WIDTH-1:0] got_row;
		logic [POS_WIDTH-1:0] got_col;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
				got_strength = m_axis_tdata[POS_WIDTH-1:0];
				got_row = m_axis_tdata[2*POS_WIDTH-1:POS_WIDTH];
				got_col = m_axis_tdata[3*POS_WIDTH-1:2*POS_WIDTH];
				if (expected_edges.size() == 0) begin
					report_mismatch($sformatf("unexpected result strength %0d at (%0d,%0d)",
						got_strength, got_row, got_col));
				end else begin
					want = expected_edges.pop_front();
					edges_checked++;
					if (got_strength !== want.strength)
						report_mismatch($sformatf("strength %0d, want %0d at (%0d,%0d)",
							got_strength, want.strength, want.row, want.col));
					if (got_row !== want.row)
						report_mismatch($sformatf("centre row %0d, want %0d",
							got_row, want.row));
					if (got_col !== want.col)
						report_mismatch($sformatf("centre column %0d, want %0d",
							got_col, want.col));
					if (m_axis_tlast !== want.frame_end)
						report_mismatch($sformatf("tlast %b, want %b at (%0d,%0d)",
							m_axis_tlast, want.frame_end, want.row, want.col));
				end
			end
		end
	end

	// receiver: random stalls plus an optional long hold-off
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_axis_tready = !hold_active && ($urandom_range(99) >= stall_pct);
		end
	end

	// long hold-off, counted here so the sender keeps offering pixels
	initial begin
		hold_active = 1'b0;
		forever begin
			@(hold_start);
			@(posedge clk);
			hold_active = 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_active = 1'b0;
		end
	end

	// watchdog: too long without any transfer
	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1) ||
				(m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("watchdog expired with %0d results outstanding", expected_edges.size());
		$display("sobel_edge_max_abs_unit regression: fail");
		$finish;
	end

	// offer one pixel, with random idle cycles first, and wait for the transfer
	task automatic send_pixel(pixel_t px);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = px;
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		pixels_sent++;
		predict_edge(px);
	endtask

	function automatic pixel_t make_pixel(int r, int g, int b);
		pixel_t px;
		px.red = CHANNEL_BITS'(r);
		px.green = CHANNEL_BITS'(g);
		px.blue = CHANNEL_BITS'(b);
		return px;
	endfunction

	// channel values lean on the extremes
	function automatic logic [CHANNEL_BITS-1:0] rand_channel();
		case ($urandom_range(3))
			0: return '0;
			1: return '1;
			default: return CHANNEL_BITS'($urandom_range(255));
		endcase
	endfunction

	function automatic pixel_t rand_pixel();
		return make_pixel(rand_channel(), rand_channel(), rand_channel());
	endfunction

	task automatic send_random_pixels(int count);
		for (int i = 0; i < count; i++)
			send_pixel(rand_pixel());
	endtask

	// stop offering, let every expected result arrive and the pipeline drain
	task automatic settle();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (expected_edges.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_WIDTH-1:0] value);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		if (idx == CFG_IMAGE_COLUMNS)
			cols_reg = value;
		else
			rows_reg = value;
		restart_frame();
		reg_writes++;
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	task automatic configure(int cols, int rows);
		settle();
		write_reg(CFG_IMAGE_COLUMNS, CFG_WIDTH'(cols));
		write_reg(CFG_IMAGE_ROWS, CFG_WIDTH'(rows));
	endtask

	task automatic set_idling(int idle, int stall);
		send_idle_pct = idle;
		stall_pct = stall;
	endtask

	// full-scale vertical and horizontal edges, channel extremes and rounding
	task automatic test_edge_extremes();
		set_idling(0, 0);
		configure(3, 3);
		// black top row, white bottom row
		for (int i = 0; i < 3; i++) send_pixel(make_pixel(0, 0, 0));
		for (int i = 0; i < 3; i++) send_pixel(make_pixel(128, 128, 128));
		for (int i = 0; i < 3; i++) send_pixel(make_pixel(255, 255, 255));
		// next frame without reconfiguring: white left column, black right
		for (int i = 0; i < 3; i++) begin
			send_pixel(make_pixel(255, 255, 255));
			send_pixel(make_pixel(255, 0, 0));
			send_pixel(make_pixel(0, 0, 0));
		end
		// mixed channels, gray truncates
		send_pixel(make_pixel(255, 255, 254));
		send_pixel(make_pixel(0, 255, 0));
		send_pixel(make_pixel(0, 0, 255));
		send_pixel(make_pixel(255, 0, 255));
		send_pixel(make_pixel(1, 1, 0));
		send_pixel(make_pixel(128, 64, 32));
		send_pixel(make_pixel(255, 255, 255));
		send_pixel(make_pixel(0, 0, 0));
		send_pixel(make_pixel(85, 170, 255));
	endtask

	// a register write mid-frame starts over at row 0, column 0
	task automatic test_frame_restart();
		set_idling(0, 0);
		configure(5, 4);
		send_random_pixels(13);
		settle();
		write_reg(CFG_IMAGE_ROWS, CFG_WIDTH'(4));
		send_random_pixels(20);
		send_random_pixels(7);
		settle();
		write_reg(CFG_IMAGE_COLUMNS, CFG_WIDTH'(6));
		send_random_pixels(24);
	endtask

	// out-of-range sizes saturate to 3 on the low side
	task automatic test_dimension_saturation();
		set_idling(32, 32);
		configure(0, 0);
		send_random_pixels(18);
		configure(2, 1);
		send_random_pixels(9);
		configure(1, 5);
		send_random_pixels(15);
		configure(7, 2);
		send_random_pixels(21);
	endtask

	// receiver holds off long enough that the block stalls its input
	task automatic test_output_backpressure();
		set_idling(0, 0);
		configure(16, 6);
		-> hold_start;
		send_random_pixels(16 * 6);
	endtask

	// random small frames, some cut short, sizes sometimes out of range
	task automatic test_random_frames(int idle, int stall, int budget);
		int start;
		int cols;
		int rows;
		int frame_pixels;
		set_idling(idle, stall);
		start = pixels_sent;
		while (pixels_sent - start < budget) begin
			cols = $urandom_range(0, 14);
			rows = $urandom_range(0, 9);
			configure(cols, rows);
			frame_pixels = clamp_dim(CFG_WIDTH'(cols), MAX_COLUMNS) *
				clamp_dim(CFG_WIDTH'(rows), MAX_ROWS);
			for (int f = $urandom_range(1, 3); f > 0; f--) begin
				if ($urandom_range(7) == 0) begin
					send_random_pixels($urandom_range(1, frame_pixels - 1));
					break;
				end
				send_random_pixels(frame_pixels);
			end
		end
	endtask

	// stimulus
	initial begin
		cfg_wr_en = 1'b0;
		cfg_index = CFG_IMAGE_COLUMNS;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		pixels_sent = 0;
		edges_checked = 0;
		reg_writes = 0;
		mismatches = 0;
		set_idling(0, 0);
		cols_reg = COLS_RESET;
		rows_reg = ROWS_RESET;
		restart_frame();
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_edge_extremes();
		test_frame_restart();
		test_dimension_saturation();
		test_output_backpressure();
		test_random_frames(0, 0, RANDOM_PIXELS / 4);
		test_random_frames(68, 0, RANDOM_PIXELS / 4);
		test_random_frames(0, 68, RANDOM_PIXELS / 4);
		test_random_frames(32, 32, RANDOM_PIXELS / 4);
		settle();

		$display("streamed %0d pixels over %0d register writes, frames 3 to 16 wide, 3 to 9 tall",
			pixels_sent, reg_writes);
		$display("checked %0d edge results with %0d mismatches", edges_checked, mismatches);
		if (mismatches == 0) begin
			$display("sobel_edge_max_abs_unit regression: pass");
		end else begin
			$display("sobel_edge_max_abs_unit regression: fail");
		end
		$finish;
	end

endmodule

>>> sim.f
design/sem_pkg.sv
design/sem_ram.sv
design/sem_cell.sv
design/sobel_edge_max_abs_unit.sv
test/sobel_edge_max_abs_unit_test.sv
